[rtl/vig_pkg.sv]
// ----------------------------------------------------------------------------
// vig_pkg
// Shared constants, types and alphabet functions for the 37-symbol cipher.
// ----------------------------------------------------------------------------
`default_nettype none

package vig_pkg;

  localparam int unsigned KEY_DIGITS_DEF = 16;
  localparam int unsigned ALPHA_SIZE     = 37;
  localparam int unsigned IDX_W          = 6;
  localparam int unsigned CHAR_W         = 8;
  localparam int unsigned LEN_W          = 5;
  localparam int unsigned CFG_DATA_W     = 64;
  localparam int unsigned CFG_ADDR_W     = 2;

  localparam logic [CHAR_W-1:0] CASE_GAP  = 8'h20;
  localparam logic [CHAR_W-1:0] NOT_FOUND = 8'h2A;  // '*'

  // Configuration register indexes
  typedef enum logic [CFG_ADDR_W-1:0] {
    CFG_ENCRYPT_MODE = 2'd0,
    CFG_KEY_NIBBLES  = 2'd1,
    CFG_KEY_LENGTH   = 2'd2
  } cfg_reg_e;

  localparam logic [CHAR_W-1:0] SYMBOLS [ALPHA_SIZE] = '{
    8'h61, 8'h41, 8'h62, 8'h63, 8'h43, 8'h64, 8'h65, 8'h45, 8'h66, 8'h67,
    8'h68, 8'h69, 8'h6A, 8'h6B, 8'h6C, 8'h4C, 8'h6D, 8'h6E, 8'h0A, 8'h4E,
    8'h6F, 8'h4F, 8'h70, 8'h71, 8'h72, 8'h73, 8'h53, 8'h74, 8'h75, 8'h76,
    8'h77, 8'h78, 8'h79, 8'h7A, 8'h58, 8'h5A, 8'h20
  };

  typedef struct packed {
    logic             found;
    logic [IDX_W-1:0] idx;
  } sym_hit_t;

  // Parallel compare against the whole alphabet; entries are distinct.
  function automatic sym_hit_t sym_lookup(input logic [CHAR_W-1:0] c);
    sym_hit_t r;
    r.found = 1'b0;
    r.idx   = '0;
    for (int i = 0; i < ALPHA_SIZE; i++) begin
      if (SYMBOLS[i] == c) begin
        r.found = 1'b1;
        r.idx   = IDX_W'(i);
      end
    end
    return r;
  endfunction

  function automatic logic [CHAR_W-1:0] sym_char(input logic [IDX_W-1:0] idx);
    logic [CHAR_W-1:0] r;
    r = NOT_FOUND;
    for (int i = 0; i < ALPHA_SIZE; i++) begin
      if (idx == IDX_W'(i)) begin
        r = SYMBOLS[i];
      end
    end
    return r;
  endfunction

endpackage

`default_nettype wire

[rtl/vig_key_seq.sv]
// ----------------------------------------------------------------------------
// vig_key_seq
// Key position counter and current key digit select.
// ----------------------------------------------------------------------------
`default_nettype none

module vig_key_seq #(
  parameter int unsigned KeyDigits = vig_pkg::KEY_DIGITS_DEF,
  parameter int unsigned PosW      = (KeyDigits > 1) ? $clog2(KeyDigits) : 1
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic [KeyDigits-1:0][3:0]        key_i,
  input  logic [vig_pkg::LEN_W-1:0]        key_len_i,
  input  logic                             step_i,
  output logic [3:0]                       digit_o,
  output logic [PosW-1:0]                  pos_o
);
  import vig_pkg::*;

  logic [PosW-1:0]  pos_q, pos_d;
  logic [LEN_W-1:0] len_c;
  logic [PosW-1:0]  pos_eff;
  logic [LEN_W:0]   pos_inc;

  // Length zero acts as one; saturate at the key storage size.
  always_comb begin
    len_c = key_len_i;
    if (len_c == '0) len_c = LEN_W'(1);
    if (len_c > LEN_W'(KeyDigits)) len_c = LEN_W'(KeyDigits);
  end

  // Stale position after the length was lowered restarts at digit 0.
  assign pos_eff = ((LEN_W+1)'(pos_q) >= (LEN_W+1)'(len_c)) ? '0 : pos_q;
  assign pos_inc = (LEN_W+1)'(pos_eff) + (LEN_W+1)'(1);

  always_comb begin
    pos_d = pos_q;
    if (step_i) begin
      pos_d = (pos_inc >= (LEN_W+1)'(len_c)) ? '0 : PosW'(pos_inc);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
    end else begin
      pos_q <= pos_d;
    end
  end

  assign digit_o = key_i[pos_eff];
  assign pos_o   = pos_q;

endmodule

`default_nettype wire

[rtl/vig_cipher_unit.sv]
// ----------------------------------------------------------------------------
// vig_cipher_unit
// Byte filter, alphabet lookup with case fold, and mod-37 shift.
// ----------------------------------------------------------------------------
`default_nettype none

module vig_cipher_unit (
  input  logic                        enc_i,
  input  logic [vig_pkg::CHAR_W-1:0]  char_i,
  input  logic [3:0]                  digit_i,
  output logic                        accept_o,
  output logic [vig_pkg::CHAR_W-1:0]  char_o
);
  import vig_pkg::*;

  sym_hit_t         hit_direct, hit_fold, hit;
  logic             is_upper, is_lower;
  logic [IDX_W:0]   sum;
  logic [IDX_W:0]   diff;
  logic [IDX_W-1:0] idx_new;

  assign is_upper = (char_i >= 8'h41) && (char_i <= 8'h5A);
  assign is_lower = (char_i >= 8'h61) && (char_i <= 8'h7A);
  assign accept_o = is_upper || is_lower ||
                    (!enc_i && ((char_i == 8'h20) || (char_i == 8'h0A)));

  assign hit_direct = sym_lookup(char_i);
  assign hit_fold   = sym_lookup(char_i + CASE_GAP);
  assign hit        = hit_direct.found ? hit_direct : hit_fold;

  assign sum  = (IDX_W+1)'(hit.idx) + (IDX_W+1)'(digit_i);
  assign diff = (IDX_W+1)'(hit.idx) - (IDX_W+1)'(digit_i);

  always_comb begin
    if (enc_i) begin
      idx_new = (sum >= (IDX_W+1)'(ALPHA_SIZE)) ? IDX_W'(sum - (IDX_W+1)'(ALPHA_SIZE))
                                                : IDX_W'(sum);
    end else begin
      // borrow out of the top bit means the difference went negative
      idx_new = diff[IDX_W] ? IDX_W'(diff + (IDX_W+1)'(ALPHA_SIZE)) : IDX_W'(diff);
    end
  end

  assign char_o = hit.found ? sym_char(idx_new) : NOT_FOUND;

endmodule

`default_nettype wire

[rtl/vigenere_37_symbol_cipher.sv]
// ----------------------------------------------------------------------------
// vigenere_37_symbol_cipher
// Byte-stream Vigenere cipher over a 37-symbol alphabet with a hex key.
// ----------------------------------------------------------------------------
// Usage:
//   Bytes enter on the s_axis channel, one word per handshake. Letters are
//   always taken; space and newline only when decrypting. Other bytes are
//   swallowed without a result and do not move the key position.
//   Each taken byte gives one word on m_axis: the alphabet symbol shifted
//   by the current key digit (+ encrypt, - decrypt, mod 37).
//   The input handshake loads the input register; the result register then
//   drives m_axis_tvalid. Throughput: one byte per cycle while the receiver
//   keeps up; the lookup and mod-37 add sit in one stage between the two
//   registers. A stalled receiver holds the result register; the input
//   register still takes one more byte, then tready drops until the result
//   drains. Config (cfg_we_i/cfg_addr_i/cfg_wdata_i) must be written only
//   while idle; the block itself does not enforce this. Reset: encrypt mode on,
//   key all zero, key length 1, position 0, both pipeline registers empty.
// ----------------------------------------------------------------------------
`default_nettype none

module vigenere_37_symbol_cipher #(
  parameter int unsigned KeyDigits = vig_pkg::KEY_DIGITS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // input stream
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [7:0]                        s_axis_tdata,   // [7:0] char_in
  // result stream
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [7:0]                        m_axis_tdata,   // [7:0] char_out
  // configuration write port
  input  logic                              cfg_we_i,
  input  logic [vig_pkg::CFG_ADDR_W-1:0]    cfg_addr_i,
  input  logic [vig_pkg::CFG_DATA_W-1:0]    cfg_wdata_i
);
  import vig_pkg::*;

  localparam int unsigned PosW = (KeyDigits > 1) ? $clog2(KeyDigits) : 1;

  // config registers
  logic                        enc_q;
  logic [KeyDigits-1:0][3:0]   key_q;
  logic [LEN_W-1:0]            key_len_q;

  // pipeline
  logic                        in_vld_q;
  logic [CHAR_W-1:0]           in_char_q;
  logic                        out_vld_q, out_vld_d;
  logic [CHAR_W-1:0]           out_char_q;

  logic                        advance;   // stage-1 word leaves this cycle
  logic                        take;      // stage-1 word is a real symbol
  logic [3:0]                  digit;
  logic [PosW-1:0]             key_pos;
  logic [CHAR_W-1:0]           cipher_char;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enc_q     <= 1'b1;
      key_q     <= '0;
      key_len_q <= LEN_W'(1);
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        CFG_ENCRYPT_MODE: enc_q     <= cfg_wdata_i[0];
        CFG_KEY_NIBBLES:  key_q     <= cfg_wdata_i[4*KeyDigits-1:0];
        CFG_KEY_LENGTH:   key_len_q <= cfg_wdata_i[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  // Result register frees up when empty or being taken downstream.
  assign advance       = in_vld_q && (!out_vld_q || m_axis_tready);
  assign s_axis_tready = !in_vld_q || advance;

  vig_key_seq #(
    .KeyDigits (KeyDigits),
    .PosW      (PosW)
  ) u_key_seq (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .key_i     (key_q),
    .key_len_i (key_len_q),
    .step_i    (advance && take),
    .digit_o   (digit),
    .pos_o     (key_pos)
  );

  vig_cipher_unit u_cipher (
    .enc_i    (enc_q),
    .char_i   (in_char_q),
    .digit_i  (digit),
    .accept_o (take),
    .char_o   (cipher_char)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_vld_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_char_q <= s_axis_tdata;
    end
  end

  always_comb begin
    out_vld_d = out_vld_q;
    if (m_axis_tready) out_vld_d = 1'b0;
    if (advance && take) out_vld_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else begin
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && take) begin
      out_char_q <= cipher_char;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_char_q;

  // ---------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------
  a_pos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (PosW+1)'(key_pos) < (PosW+1)'(KeyDigits))
    else $error("key position beyond key storage");

  a_pos_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(advance && take) |=> $stable(key_pos))
    else $error("key position moved without a taken symbol");

  a_result_loaded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && take) |=> m_axis_tvalid)
    else $error("taken symbol produced no result");

  a_no_star: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata != NOT_FOUND))
    else $error("symbol missing from alphabet");

endmodule

`default_nettype wire

[dv/vigenere_37_symbol_cipher_tb.sv]
// ----------------------------------------------------------------------------
// vigenere_37_symbol_cipher_tb
// Self-checking bench for the 37-symbol cipher: a shadow model in a small
// class predicts every output word from the words accepted on s_axis and
// the programmed key, and checks the m_axis words in order.
// ----------------------------------------------------------------------------
`default_nettype none

module vigenere_37_symbol_cipher_tb;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned SYM_COUNT      = 37;
  localparam int unsigned MAX_KEY_DIGITS = 16;
  localparam int unsigned WATCHDOG_LIMIT = 1000;  // quiet cycles before giving up
  localparam int unsigned DRAIN_PAD      = 8;     // covers the two-stage pipe
  localparam int unsigned HOLD_CYCLES    = 60;    // long receiver hold-off
  localparam int unsigned PHASE_WORDS    = 88;    // cipher words per random phase

  localparam logic [7:0] CH_SPACE    = 8'h20;
  localparam logic [7:0] CH_NEWLINE  = 8'h0A;
  localparam logic [7:0] CH_STAR     = 8'h2A;
  localparam logic [7:0] CASE_OFFSET = 8'h20;

  // Cipher alphabet: mixed-case letters with newline among them, and space last.
  localparam logic [7:0] ALPHABET [SYM_COUNT] = '{
    8'h61, 8'h41, 8'h62, 8'h63, 8'h43, 8'h64, 8'h65, 8'h45, 8'h66, 8'h67,
    8'h68, 8'h69, 8'h6A, 8'h6B, 8'h6C, 8'h4C, 8'h6D, 8'h6E, 8'h0A, 8'h4E,
    8'h6F, 8'h4F, 8'h70, 8'h71, 8'h72, 8'h73, 8'h53, 8'h74, 8'h75, 8'h76,
    8'h77, 8'h78, 8'h79, 8'h7A, 8'h58, 8'h5A, 8'h20
  };

  // Directed bytes while encrypting with a 16-digit key: letter extremes,
  // uppercase letters missing from the alphabet, and bytes that get dropped
  // (space and newline included, since they only pass when decrypting).
  localparam logic [7:0] DIRECTED_ENC [14] = '{
    8'h41, 8'h5A, 8'h61, 8'h7A, 8'h42, 8'h78, 8'h58,
    8'h00, 8'hFF, CH_SPACE, CH_NEWLINE, 8'h40, 8'h5B, 8'h7B
  };
  // Directed bytes while decrypting: space and newline now pass.
  localparam logic [7:0] DIRECTED_DEC [8] = '{
    CH_SPACE, CH_NEWLINE, 8'h5A, 8'h61, 8'h4D, 8'h80, 8'h7F, 8'h60
  };

  // --------------------------------------------------------------------------
  // Shadow of the cipher: register copies, key position, expected words
  // --------------------------------------------------------------------------
  class cipher_shadow;
    logic        encrypt;
    logic [63:0] key;
    logic [4:0]  key_len;
    logic [3:0]  key_pos;
    logic [7:0]  cipher_q [$];
    int unsigned errors;

    function new();
      encrypt = 1'b1;
      key     = '0;
      key_len = 5'd1;
      key_pos = '0;
      errors  = 0;
    endfunction

    function void set_reg(vig_pkg::cfg_reg_e r, logic [63:0] v);
      case (r)
        vig_pkg::CFG_ENCRYPT_MODE: encrypt = v[0];
        vig_pkg::CFG_KEY_NIBBLES:  key     = v;
        vig_pkg::CFG_KEY_LENGTH:   key_len = v[4:0];
        default: ;
      endcase
    endfunction

    function int sym_pos(logic [7:0] c);
      int r;
      r = -1;
      for (int i = 0; i < SYM_COUNT; i++)
        if (ALPHABET[i] == c) r = i;
      return r;
    endfunction

    // Returns 1 when the byte passes the filter and a word is expected.
    function bit note_plain(logic [7:0] c);
      bit   is_letter;
      int   len;
      int   pos;
      int   digit;
      int   idx;
      is_letter = (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A);
      if (!is_letter && !(!encrypt && (c == CH_SPACE || c == CH_NEWLINE)))
        return 1'b0;
      // length 0 acts as 1, anything past the key width saturates
      len = (key_len == 0) ? 1 : int'(key_len);
      if (len > MAX_KEY_DIGITS) len = MAX_KEY_DIGITS;
      // a stale position past a lowered length restarts at digit 0
      pos = int'(key_pos);
      if (pos >= len) pos = 0;
      digit = int'((key >> (4 * pos)) & 64'hF);
      pos++;
      if (pos >= len) pos = 0;
      key_pos = 4'(pos);
      idx = sym_pos(c);
      if (idx < 0) idx = sym_pos(c + CASE_OFFSET);  // uppercase missing: use lowercase
      if (idx < 0) begin
        cipher_q.push_back(CH_STAR);
        return 1'b1;
      end
      if (encrypt) begin
        idx += digit;
        if (idx >= SYM_COUNT) idx -= SYM_COUNT;
      end else begin
        idx -= digit;
        if (idx < 0) idx += SYM_COUNT;
      end
      cipher_q.push_back(ALPHABET[idx]);
      return 1'b1;
    endfunction

    function void check_cipher(logic [7:0] got);
      logic [7:0] want;
      if (cipher_q.size() == 0) begin
        $error("char_out: unexpected word, expected none, actual %02h", got);
        errors++;
        return;
      end
      want = cipher_q.pop_front();
      if (got !== want) begin
        $error("char_out mismatch: expected %02h, actual %02h", want, got);
        errors++;
      end
    endfunction

    function int pending();
      return cipher_q.size();
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Clock, reset, DUT
  // --------------------------------------------------------------------------
  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  logic                           s_axis_tvalid = 1'b0;
  logic                           s_axis_tready;
  logic [7:0]                     s_axis_tdata  = '0;   // [7:0] char_in
  logic                           m_axis_tvalid;
  logic                           m_axis_tready = 1'b0;
  logic [7:0]                     m_axis_tdata;         // [7:0] char_out
  logic                           cfg_we_i      = 1'b0;
  logic [vig_pkg::CFG_ADDR_W-1:0] cfg_addr_i    = vig_pkg::CFG_ENCRYPT_MODE;
  logic [vig_pkg::CFG_DATA_W-1:0] cfg_wdata_i   = '0;

  always #5 clk_i = ~clk_i;

  vigenere_37_symbol_cipher dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we_i),
    .cfg_addr_i    (cfg_addr_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  cipher_shadow shadow = new();

  int unsigned src_idle_pct = 0;
  int unsigned snk_stall_pct = 0;
  bit          hold_req = 1'b0;     // raised by the stimulus, taken by the receiver
  int unsigned hold_left = 0;
  int unsigned quiet_cycles = 0;

  // --------------------------------------------------------------------------
  // Receiver: checks each accepted word, then picks next cycle's tready.
  // All handshakes are sampled at the edge before NBA updates land.
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) shadow.check_cipher(m_axis_tdata);
      if (hold_req) begin
        hold_left = HOLD_CYCLES;
        hold_req  = 1'b0;
      end
      if (hold_left != 0) begin
        // long hold-off: the pipe fills and s_axis_tready must drop
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= snk_stall_pct);
      end
    end
  end

  // Watchdog: only cycles without any word moving count toward the limit.
  always @(posedge clk_i) begin
    if (!rst_ni || cfg_we_i || (s_axis_tvalid && s_axis_tready) ||
        (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Driver tasks
  // --------------------------------------------------------------------------

  // Offer one byte, with random idle cycles ahead of it; returns whether the
  // byte should produce a cipher word.
  task automatic send_byte(input logic [7:0] c, output bit produced);
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= c;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    produced = shadow.note_plain(c);
  endtask

  // Wait until every expected word has arrived, plus time for a dropped
  // byte still in the pipe to clear.
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (shadow.pending() != 0) @(posedge clk_i);
    repeat (DRAIN_PAD) @(posedge clk_i);
  endtask

  task automatic write_reg(input vig_pkg::cfg_reg_e r, input logic [63:0] v);
    cfg_we_i    <= 1'b1;
    cfg_addr_i  <= r;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    shadow.set_reg(r, v);
  endtask

  // Reprogram all three registers while the block is idle. The key position
  // is not touched, so it may now lie past a shorter length.
  task automatic program_cipher(input logic mode, input logic [63:0] key,
                                input logic [4:0] len);
    drain();
    write_reg(vig_pkg::CFG_ENCRYPT_MODE, {63'd0, mode});
    write_reg(vig_pkg::CFG_KEY_NIBBLES, key);
    write_reg(vig_pkg::CFG_KEY_LENGTH, {59'd0, len});
    cfg_we_i <= 1'b0;
  endtask

  // Mostly letters, some space/newline, the rest any byte at all.
  function automatic logic [7:0] pick_byte();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 38) return 8'($urandom_range(8'h5A, 8'h41));
    if (r < 76) return 8'($urandom_range(8'h7A, 8'h61));
    if (r < 83) return CH_SPACE;
    if (r < 88) return CH_NEWLINE;
    return 8'($urandom_range(255));
  endfunction

  // Random stream until n_words cipher words are owed; hold_at > 0 starts
  // a long receiver hold-off after that many.
  task automatic run_words(input int unsigned n_words, input int unsigned hold_at);
    int unsigned done_words;
    bit          produced;
    done_words = 0;
    while (done_words < n_words) begin
      send_byte(pick_byte(), produced);
      if (produced) begin
        done_words++;
        if (done_words == hold_at) hold_req = 1'b1;
      end
    end
  endtask

  task automatic set_idling(input int unsigned src, input int unsigned snk);
    src_idle_pct  = src;
    snk_stall_pct = snk;
  endtask

  // --------------------------------------------------------------------------
  // Test sequence
  // --------------------------------------------------------------------------
  initial begin
    bit produced;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: reset settings first (encrypt, zero key, length 1).
    set_idling(24, 76);
    send_byte(8'h41, produced);
    send_byte(8'h5A, produced);

    program_cipher(1'b1, 64'hFEDC_BA98_7654_3210, 5'd16);
    foreach (DIRECTED_ENC[i]) send_byte(DIRECTED_ENC[i], produced);

    // Position is past 3 here, so this also covers the stale-position case.
    program_cipher(1'b0, 64'hFEDC_BA98_7654_3210, 5'd3);
    foreach (DIRECTED_DEC[i]) send_byte(DIRECTED_DEC[i], produced);

    // Random phases: sender lazy / receiver stalling first.
    program_cipher(1'b1, {$urandom, $urandom}, 5'd16);
    run_words(PHASE_WORDS, 0);
    program_cipher(1'b0, {$urandom, $urandom}, 5'd5);
    run_words(PHASE_WORDS, 40);

    // Then the other way round; all-ones key, length 0 and saturated length.
    set_idling(76, 24);
    program_cipher(1'b1, '1, 5'd0);
    run_words(PHASE_WORDS, 0);
    program_cipher(1'b0, '1, 5'd31);
    run_words(PHASE_WORDS, 0);

    // No idling at all; hold-off here hits a sender running at full rate.
    set_idling(0, 0);
    program_cipher(1'b1, {$urandom, $urandom}, 5'd1);
    run_words(PHASE_WORDS, 30);
    program_cipher(1'b0, {$urandom, $urandom}, 5'($urandom_range(31)));
    run_words(PHASE_WORDS, 0);

    drain();
    if (shadow.errors == 0 && shadow.pending() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

`default_nettype wire
